// ===== hw/rtl/ising_metropolis_sweep_unit_assert.svh =====
// Assertion macros for the Ising Metropolis sweep unit
`ifndef ISING_METROPOLIS_SWEEP_UNIT_ASSERT_SVH
`define ISING_METROPOLIS_SWEEP_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define IMS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising edge, off during reset
`define IMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ims_pkg.sv =====
// Shared types and constants for the Ising Metropolis sweep unit
package ims_pkg;

   localparam int COORD_W    = 6;
   localparam int PROB_W     = 16;
   localparam int SIDE_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SIDE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_TWO  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_FOUR = 2'd2;

   typedef struct packed {
      logic               kind;
      logic [PROB_W-1:0]  random_value;
      logic [COORD_W-1:0] read_row;
      logic [COORD_W-1:0] read_col;
   } ims_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] site_row;
      logic [COORD_W-1:0] site_col;
      logic               spin_up;
      logic               flipped;
      logic               sweep_end;
   } ims_rsp_type;

   typedef struct packed {
      logic centre;
      logic up;
      logic down;
      logic left;
      logic right;
   } ims_nbr_type;

endpackage

// ===== hw/rtl/ims_spin_ram.sv =====
// Row-wide spin memory: one write port, one registered read port with enable
module ims_spin_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/ims_flip_decide.sv =====
// Metropolis acceptance test from the centre spin and its four neighbours
module ims_flip_decide (
   input  ims_pkg::ims_nbr_type            nbr,
   input  logic [ims_pkg::PROB_W-1:0]      random_value,
   input  logic [ims_pkg::PROB_W-1:0]      prob_two,
   input  logic [ims_pkg::PROB_W-1:0]      prob_four,
   output logic                            flip
);
   import ims_pkg::*;

   logic [2:0] agree;

   assign agree = {2'b00, nbr.up    ~^ nbr.centre}
                + {2'b00, nbr.down  ~^ nbr.centre}
                + {2'b00, nbr.left  ~^ nbr.centre}
                + {2'b00, nbr.right ~^ nbr.centre};

   always_comb begin
      case (agree)
         3'd3:    flip = random_value < prob_two;
         3'd4:    flip = random_value < prob_four;
         default: flip = 1'b1;
      endcase
   end

endmodule

// ===== hw/rtl/ising_metropolis_sweep_unit.sv =====
// Top level of the Ising Metropolis sweep unit: sequencer, registers and spin store
//
//   channel  direction  handshake                     word
//   req      in         req_valid / req_ready         ims_req_type
//   rsp      out        rsp_valid / rsp_ready         ims_rsp_type
//   csr      in         csr_we, no wait               csr_index, csr_wdata
//
// An update reads three rows (up, centre, down) in IDLE, CTR and DN on the single
// read port of the spin memory, then evaluates and writes back the centre row in EVAL.
// A read fetches its row in IDLE and answers from RDOUT. One word waits in the input register meanwhile.
// After reset a clearing pass sets every row to +1 spins;
// req_ready stays low during it. A stalled rsp holds the last step in place.
module ising_metropolis_sweep_unit #(
   parameter int SIDE_MAX = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ims_pkg::ims_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ims_pkg::ims_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [ims_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ims_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ims_pkg::*;

   localparam int RW = (SIDE_MAX > 1) ? $clog2(SIDE_MAX) : 1;
   localparam int NW = $clog2(SIDE_MAX + 1);
   localparam int CW = (NW > SIDE_W) ? NW : SIDE_W;
   localparam logic [CW-1:0]       SIDE_MAX_C = CW'(SIDE_MAX);
   localparam logic [CW-1:0]       SIDE_MIN_C = CW'(2);
   localparam logic [RW-1:0]       LAST_ROW   = RW'(SIDE_MAX - 1);
   localparam logic [SIDE_MAX-1:0] ONE_BIT    = SIDE_MAX'(1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CTR   = 3'd2;
   localparam logic [2:0] ST_DN    = 3'd3;
   localparam logic [2:0] ST_EVAL  = 3'd4;
   localparam logic [2:0] ST_RDOUT = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [RW-1:0]       clr_ff, clr_in;
   logic [SIDE_W-1:0]   side_ff;
   logic [PROB_W-1:0]   prob_two_ff, prob_four_ff;
   logic                buf_valid_ff;
   ims_req_type         buf_ff;
   logic [RW-1:0]       cur_row_ff, cur_col_ff;
   logic [RW-1:0]       wi_ff, wj_ff, dn_ff;
   logic [PROB_W-1:0]   rnd_ff;
   logic                rd_in_store_ff;
   logic [COORD_W-1:0]  rd_row_ff, rd_col_ff;
   logic [SIDE_MAX-1:0] up_row_ff, ctr_row_ff;
   logic                rsp_valid_ff;
   ims_rsp_type         rsp_ff, rsp_in;

   logic                ram_we, ram_re;
   logic [RW-1:0]       ram_waddr, ram_raddr;
   logic [SIDE_MAX-1:0] ram_wdata, ram_rdata;

   logic [CW-1:0]       side_ext;
   logic [NW-1:0]       n_c;
   logic                cur_bad;
   logic [RW-1:0]       i_c, j_c, up_row_c, dn_row_c, lf_c, rt_c;
   logic [NW-1:0]       col_nx, row_nx;
   logic                row_wrap, sweep_end_c;
   ims_nbr_type         nbr;
   logic                flip;
   logic                take, out_free, fire;
   logic                req_take;

   // clamp the active side
   assign side_ext = CW'(side_ff);
   assign n_c = (side_ext < SIDE_MIN_C) ? NW'(SIDE_MIN_C) :
                (side_ext > SIDE_MAX_C) ? NW'(SIDE_MAX_C) : NW'(side_ext);

   // restart the cursor when it lies outside the active lattice
   assign cur_bad  = (NW'(cur_row_ff) >= n_c) || (NW'(cur_col_ff) >= n_c);
   assign i_c      = cur_bad ? '0 : cur_row_ff;
   assign j_c      = cur_bad ? '0 : cur_col_ff;
   assign up_row_c = (i_c == '0) ? RW'(n_c - NW'(1)) : i_c - RW'(1);
   assign dn_row_c = ((NW'(i_c) + NW'(1)) == n_c) ? '0 : i_c + RW'(1);

   assign lf_c = (wj_ff == '0) ? RW'(n_c - NW'(1)) : wj_ff - RW'(1);
   assign rt_c = ((NW'(wj_ff) + NW'(1)) == n_c) ? '0 : wj_ff + RW'(1);

   assign nbr.centre = ctr_row_ff[wj_ff];
   assign nbr.up     = up_row_ff[wj_ff];
   assign nbr.down   = ram_rdata[wj_ff];
   assign nbr.left   = ctr_row_ff[lf_c];
   assign nbr.right  = ctr_row_ff[rt_c];

   assign col_nx      = NW'(wj_ff) + NW'(1);
   assign row_nx      = NW'(wi_ff) + NW'(1);
   assign row_wrap    = (col_nx == n_c);
   assign sweep_end_c = row_wrap && (row_nx == n_c);

   ims_flip_decide u_decide (
      .nbr          (nbr),
      .random_value (rnd_ff),
      .prob_two     (prob_two_ff),
      .prob_four    (prob_four_ff),
      .flip         (flip)
   );

   ims_spin_ram #(
      .DEPTH (SIDE_MAX),
      .WIDTH (SIDE_MAX),
      .AW    (RW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign take      = buf_valid_ff && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !buf_valid_ff && (state_ff != ST_CLEAR);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '1;
      ram_re    = 1'b0;
      ram_raddr = wi_ff;
      fire      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + RW'(1);
            if (clr_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (buf_valid_ff) begin
               ram_re = 1'b1;
               if (buf_ff.kind == KIND_READ) begin
                  ram_raddr = RW'(buf_ff.read_row);
                  state_in  = ST_RDOUT;
               end else begin
                  ram_raddr = up_row_c;
                  state_in  = ST_CTR;
               end
            end
         end
         ST_CTR: begin
            ram_re    = 1'b1;
            ram_raddr = wi_ff;
            state_in  = ST_DN;
         end
         ST_DN: begin
            ram_re    = 1'b1;
            ram_raddr = dn_ff;
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            if (out_free) begin
               ram_we    = 1'b1;
               ram_waddr = wi_ff;
               ram_wdata = ctr_row_ff ^ (flip ? (ONE_BIT << wj_ff) : '0);
               fire      = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_RDOUT: begin
            if (out_free) begin
               fire     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (state_ff == ST_RDOUT) begin
         rsp_in.site_row  = rd_row_ff;
         rsp_in.site_col  = rd_col_ff;
         rsp_in.spin_up   = rd_in_store_ff && ram_rdata[RW'(rd_col_ff)];
         rsp_in.flipped   = 1'b0;
         rsp_in.sweep_end = 1'b0;
      end else begin
         rsp_in.site_row  = COORD_W'(wi_ff);
         rsp_in.site_col  = COORD_W'(wj_ff);
         rsp_in.spin_up   = nbr.centre ^ flip;
         rsp_in.flipped   = flip;
         rsp_in.sweep_end = sweep_end_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= SIDE_RESET;
         prob_two_ff  <= '0;
         prob_four_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SIDE:      side_ff      <= csr_wdata[SIDE_W-1:0];
            CSR_PROB_TWO:  prob_two_ff  <= csr_wdata[PROB_W-1:0];
            CSR_PROB_FOUR: prob_four_ff <= csr_wdata[PROB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else if (req_take) begin
         buf_valid_ff <= 1'b1;
      end else if (take) begin
         buf_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         buf_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         wi_ff          <= i_c;
         wj_ff          <= j_c;
         dn_ff          <= dn_row_c;
         rnd_ff         <= buf_ff.random_value;
         rd_row_ff      <= buf_ff.read_row;
         rd_col_ff      <= buf_ff.read_col;
         rd_in_store_ff <= (32'(buf_ff.read_row) < SIDE_MAX)
                        && (32'(buf_ff.read_col) < SIDE_MAX);
      end
      if (state_ff == ST_CTR) begin
         up_row_ff <= ram_rdata;
      end
      if (state_ff == ST_DN) begin
         ctr_row_ff <= ram_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
      end else if (fire && (state_ff == ST_EVAL)) begin
         if (row_wrap) begin
            cur_col_ff <= '0;
            cur_row_ff <= sweep_end_c ? '0 : RW'(row_nx);
         end else begin
            cur_row_ff <= wi_ff;
            cur_col_ff <= RW'(col_nx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "ising_metropolis_sweep_unit_assert.svh"

   `IMS_ASSERT_NOW(a_no_req_in_clear, state_ff == ST_CLEAR, !req_ready, "word taken while clearing")
   `IMS_ASSERT_NOW(a_write_slot, ram_we, (state_ff == ST_EVAL) || (state_ff == ST_CLEAR), "stray spin write")
   `IMS_ASSERT_NEXT(a_sweep_wrap, fire && (state_ff == ST_EVAL) && sweep_end_c, (cur_row_ff == '0) && (cur_col_ff == '0), "cursor not restarted after sweep")
   `IMS_ASSERT_NEXT(a_fire_shows, fire, rsp_valid_ff, "result lost")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the Ising Metropolis sweep unit: directed and random words

module tb_top;
   import ims_pkg::*;

   localparam int SIDE_MAX      = 64;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_WORDS   = 125;
   localparam int REPORT_MAX    = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   ims_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   ims_rsp_type           rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit                spin_lattice [SIDE_MAX*SIDE_MAX];
   int                next_row;
   int                next_col;
   logic [SIDE_W-1:0] side_reg;
   logic [PROB_W-1:0] prob_two;
   logic [PROB_W-1:0] prob_four;

   ims_rsp_type expected_sites [$];
   int          mismatches  = 0;
   int          burst_left  = 0;
   int          quiet_count = 0;
   logic [7:0]  stall_bits  = 8'hFF;
   int          stall_left  = 0;
   int          stall_mode  = 0;

   ising_metropolis_sweep_unit #(.SIDE_MAX(SIDE_MAX)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int lattice_spin(input int r, input int c);
      return spin_lattice[r * SIDE_MAX + c] ? 1 : -1;
   endfunction

   function automatic ims_rsp_type metropolis_step(input ims_req_type w);
      ims_rsp_type r;
      int          n;
      int          i;
      int          j;
      int          centre;
      int          nbr_sum;
      int          prod;
      int          idx;
      bit          flip;
      r = '0;
      if (w.kind == KIND_READ) begin
         r.site_row = w.read_row;
         r.site_col = w.read_col;
         r.spin_up  = spin_lattice[int'(w.read_row) * SIDE_MAX + int'(w.read_col)];
         return r;
      end
      n = (side_reg < 2) ? 2 : (side_reg > SIDE_MAX) ? SIDE_MAX : int'(side_reg);
      if (next_row >= n || next_col >= n) begin
         next_row = 0;
         next_col = 0;
      end
      i = next_row;
      j = next_col;
      centre  = lattice_spin(i, j);
      nbr_sum = lattice_spin((i + n - 1) % n, j) + lattice_spin((i + 1) % n, j)
              + lattice_spin(i, (j + 1) % n) + lattice_spin(i, (j + n - 1) % n);
      prod = -centre * nbr_sum;
      if (prod >= 0) begin
         flip = 1'b1;
      end else if (prod == -2) begin
         flip = w.random_value < prob_two;
      end else begin
         flip = w.random_value < prob_four;
      end
      idx = i * SIDE_MAX + j;
      if (flip) begin
         spin_lattice[idx] = !spin_lattice[idx];
      end
      next_col = j + 1;
      if (next_col >= n) begin
         next_col = 0;
         next_row = i + 1;
         if (next_row >= n) begin
            next_row    = 0;
            r.sweep_end = 1'b1;
         end
      end
      r.site_row = COORD_W'(i);
      r.site_col = COORD_W'(j);
      r.spin_up  = spin_lattice[idx];
      r.flipped  = flip;
      return r;
   endfunction

   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (expected_sites.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SIDE:      side_reg  = value[SIDE_W-1:0];
         CSR_PROB_TWO:  prob_two  = value;
         CSR_PROB_FOUR: prob_four = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_word(input ims_req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      expected_sites.push_back(metropolis_step(w));
   endtask

   task automatic send_update(input logic [PROB_W-1:0] rnd);
      ims_req_type w;
      w              = '0;
      w.kind         = KIND_UPDATE;
      w.random_value = rnd;
      w.read_row     = COORD_W'($urandom);
      w.read_col     = COORD_W'($urandom);
      send_word(w);
   endtask

   task automatic send_read(input int r, input int c, input logic [PROB_W-1:0] rnd);
      ims_req_type w;
      w.kind         = KIND_READ;
      w.random_value = rnd;
      w.read_row     = COORD_W'(r);
      w.read_col     = COORD_W'(c);
      send_word(w);
   endtask

   task automatic test_reset_lattice();
      send_read(0, 0, 16'hFFFF);
      send_read(SIDE_MAX - 1, SIDE_MAX - 1, 16'h0000);
      send_read(0, SIDE_MAX - 1, 16'hA5A5);
      send_read(SIDE_MAX - 1, 0, 16'h5A5A);
   endtask

   task automatic test_acceptance_edges();
      write_csr(CSR_SIDE, 16'hFF81);
      write_csr(CSR_PROB_FOUR, 16'h0000);
      send_update(16'h0000);
      write_csr(CSR_PROB_FOUR, 16'hFFFF);
      send_update(16'hFFFF);
      send_update(16'hFFFE);
      send_update(16'h0000);
      write_csr(CSR_PROB_TWO, 16'h8000);
      send_update(16'h7FFF);
      send_update(16'h8000);
      send_update(16'h0001);
      send_read(1, 0, 16'hFFFF);
      send_read(1, 1, 16'h0000);
   endtask

   task automatic test_side_limits();
      write_csr(CSR_SIDE, 16'h0000);
      send_update(16'h1234);
      send_update(16'hFEDC);
      write_csr(CSR_SIDE, 16'h007F);
      send_update(16'h0000);
      send_update(16'hFFFF);
      write_csr(CSR_SIDE, 16'd65);
      send_update(16'h4321);
   endtask

   task automatic test_shrink_midsweep();
      write_csr(CSR_SIDE, 16'd64);
      repeat (5) send_update(16'($urandom));
      write_csr(CSR_SIDE, 16'd3);
      send_update(16'($urandom));
      send_update(16'($urandom));
      write_csr(CSR_UNUSED, 16'hFFFF);
      repeat (3) send_update(16'($urandom));
   endtask

   task automatic test_random_sweeps();
      ims_req_type       w;
      logic [8:0]        junk;
      logic [SIDE_W-1:0] side_pick;
      logic [PROB_W-1:0] prob_pick;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       side_pick = 7'd2;
            1:       side_pick = 7'd3;
            2:       side_pick = SIDE_W'($urandom_range(4, 8));
            3:       side_pick = 7'd64;
            4:       side_pick = SIDE_W'($urandom_range(0, 127));
            default: side_pick = SIDE_W'($urandom_range(9, 16));
         endcase
         junk = 9'($urandom);
         write_csr(CSR_SIDE, {junk, side_pick});
         for (int k = 0; k < 2; k++) begin
            case ($urandom_range(0, 3))
               0:       prob_pick = 16'h0000;
               1:       prob_pick = 16'hFFFF;
               default: prob_pick = 16'($urandom);
            endcase
            write_csr((k == 0) ? CSR_PROB_TWO : CSR_PROB_FOUR, prob_pick);
         end
         if ($urandom_range(0, 3) == 0) begin
            write_csr(CSR_UNUSED, 16'($urandom));
         end
         for (int k = 0; k < PHASE_WORDS; k++) begin
            w.kind         = ($urandom_range(0, 4) == 0) ? KIND_READ : KIND_UPDATE;
            w.random_value = 16'($urandom);
            if ($urandom_range(0, 1) == 0) begin
               w.read_row = COORD_W'($urandom);
               w.read_col = COORD_W'($urandom);
            end else begin
               w.read_row = COORD_W'($urandom_range(0, 7));
               w.read_col = COORD_W'($urandom_range(0, 7));
            end
            send_word(w);
         end
      end
   endtask

   always @(posedge clock) begin : rsp_side
      ims_rsp_type want;
      if (reset) begin
         quiet_count = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sites.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("unexpected word: row %0d col %0d spin %0b flip %0b end %0b",
                     rsp_data.site_row, rsp_data.site_col, rsp_data.spin_up,
                     rsp_data.flipped, rsp_data.sweep_end);
               end
            end else begin
               want = expected_sites.pop_front();
               if (want.site_row != rsp_data.site_row || want.site_col != rsp_data.site_col
                     || want.spin_up != rsp_data.spin_up || want.flipped != rsp_data.flipped
                     || want.sweep_end != rsp_data.sweep_end) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("mismatch: exp row %0d col %0d spin %0b flip %0b end %0b",
                        want.site_row, want.site_col, want.spin_up, want.flipped,
                        want.sweep_end);
                     $display("          got row %0d col %0d spin %0b flip %0b end %0b",
                        rsp_data.site_row, rsp_data.site_col, rsp_data.spin_up,
                        rsp_data.flipped, rsp_data.sweep_end);
                  end
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_count = 0;
         end else begin
            quiet_count++;
         end
         if (quiet_count >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            if (stall_left == 0) begin
               stall_left = $urandom_range(16, 96);
               stall_mode = $urandom_range(0, 3);
               stall_bits = 8'($urandom);
               if (stall_mode == 2) begin
                  stall_bits = stall_bits & 8'($urandom);
               end
               stall_bits[0] = 1'b1;
            end
            stall_left--;
            stall_bits = {stall_bits[6:0], stall_bits[7]};
            rsp_ready <= (stall_mode == 0) ? 1'b1 : stall_bits[0];
         end
      end
   end

   initial begin
      foreach (spin_lattice[k]) spin_lattice[k] = 1'b1;
      next_row  = 0;
      next_col  = 0;
      side_reg  = SIDE_RESET;
      prob_two  = '0;
      prob_four = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_lattice();
      test_acceptance_edges();
      test_side_limits();
      test_shrink_midsweep();
      test_random_sweeps();
      wait_idle();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== ising_metropolis_sweep_unit.f =====
+incdir+hw/rtl
hw/rtl/ims_pkg.sv
hw/rtl/ims_spin_ram.sv
hw/rtl/ims_flip_decide.sv
hw/rtl/ising_metropolis_sweep_unit.sv
bench/tb_top.sv
